[rtl/pwgrle_pkg.sv]
// Shared types, codes and constants of the raster line encoder.
// Used by every module under rtl/; depends on nothing else.
package pwgrle_pkg;

    // Default and fixed field widths
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int BPP_W         = 3;
    localparam int LINE_W_W      = 13;
    localparam int PAGE_H_W      = 16;
    localparam int PIX_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int USER_W        = 5;

    // Run and repeat limits
    localparam logic [7:0] RUN_MAX   = 8'd128;
    localparam logic [8:0] LIT_BASE  = 9'd257;
    localparam logic [7:0] REP_LIMIT = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Item mode on the input side
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Token kinds
    typedef enum logic [1:0] {
        KIND_REPEAT = 2'd0,
        KIND_CTRL   = 2'd1,
        KIND_PIXEL  = 2'd2
    } t_kind;

    // What is waiting to be emitted
    typedef enum logic [1:0] {
        PEND_NONE      = 2'd0,
        PEND_SWAP      = 2'd1,
        PEND_PAGE      = 2'd2,
        PEND_SWAP_PAGE = 2'd3
    } t_pend;

    // Which token comes next in an emission
    typedef enum logic [1:0] {
        PH_REPEAT = 2'd0,
        PH_CTRL   = 2'd1,
        PH_LIT    = 2'd2,
        PH_RPIX   = 2'd3
    } t_phase;

    // Configuration values as the datapath sees them
    typedef struct packed {
        logic [PIX_W-1:0]    mask;
        logic [PAGE_H_W-1:0] height;
    } t_cfg;

    // Byte mask for the pixel width; zero acts as one, above four as four
    function automatic logic [PIX_W-1:0] pix_mask(input logic [BPP_W-1:0] bpp);
        logic [PIX_W-1:0] m;
        m = 32'hFFFF_FFFF;
        if (bpp <= 3'd1) begin
            m = 32'h0000_00FF;
        end else if (bpp == 3'd2) begin
            m = 32'h0000_FFFF;
        end else if (bpp == 3'd3) begin
            m = 32'h00FF_FFFF;
        end
        return m;
    endfunction

    // Result flags, lowest bit first: accepted, token_valid, token_kind, page_last
    function automatic logic [USER_W-1:0] pack_user(input logic acc, input logic vld,
                                                    input t_kind kind, input logic plast);
        return {plast, kind, vld, acc};
    endfunction

endpackage

[rtl/pwg_raster_line_encoder.sv]
// Top level of the raster line encoder: configuration registers, line stores
// and sequencer. Depends on pwgrle_pkg, pwgrle_store and pwgrle_ctrl.
//
// Items are taken one at a time. A pixel push passes through accept, line
// store read for the comparison and result slot; a repeat byte goes from
// accept straight to the result slot; a run pixel has accept, line store
// read and result slot. A control byte scans the held line through the
// single read port of the line store, one pixel every cycle, until the
// run breaks or reaches the line end or 128 pixels. Results wait in an output
// register, so the next item is accepted while a result is still unclaimed.
// Configuration writes are taken at any time and should only be issued while
// the block is idle.
module pwg_raster_line_encoder #(
    parameter int MAX_WIDTH = pwgrle_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwgrle_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwgrle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pwgrle_pkg::PIX_W-1:0]        i_s_axis_tdata,  // pixel_value
    input  logic [0:0]                          i_s_axis_tuser,  // mode
    // Result items
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [pwgrle_pkg::PIX_W-1:0]        o_m_axis_tdata,  // token_value
    // accepted, token_valid, token_kind[1:0], page_last
    output logic [pwgrle_pkg::USER_W-1:0]       o_m_axis_tuser,
    output logic                                o_m_axis_tlast   // line_last
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WW > pwgrle_pkg::LINE_W_W) ? WW : pwgrle_pkg::LINE_W_W;

    logic [pwgrle_pkg::BPP_W-1:0]    r_bpp;
    logic [pwgrle_pkg::LINE_W_W-1:0] r_line_w;
    logic [pwgrle_pkg::PAGE_H_W-1:0] r_page_h;
    logic [CW-1:0]                   line_w_ext;
    logic [CW-1:0]                   eff_w;
    pwgrle_pkg::t_cfg                cfg;

    logic                         wr_en, wr_bank, rd_en, rd_bank;
    logic [AW-1:0]                wr_addr, rd_addr;
    logic [pwgrle_pkg::PIX_W-1:0] wr_data, rd_data;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= 3'd1;
            r_line_w <= 13'd1;
            r_page_h <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pwgrle_pkg::CFG_BPP:    r_bpp    <= i_cfg_data[pwgrle_pkg::BPP_W-1:0];
                pwgrle_pkg::CFG_WIDTH:  r_line_w <= i_cfg_data[pwgrle_pkg::LINE_W_W-1:0];
                pwgrle_pkg::CFG_HEIGHT: r_page_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective width and height: zero acts as one, width capped at the store depth
    assign line_w_ext = CW'(r_line_w);
    always_comb begin
        eff_w = line_w_ext;
        if (r_line_w == '0) begin
            eff_w = CW'(1);
        end else if (line_w_ext > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end
    end
    assign cfg.mask   = pwgrle_pkg::pix_mask(r_bpp);
    assign cfg.height = (r_page_h == '0) ? 16'd1 : r_page_h;

    pwgrle_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_bank (wr_bank),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_bank (rd_bank),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pwgrle_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_width     (eff_w),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_mode   (i_s_axis_tuser[0]),
        .i_in_pixel  (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .o_wr_en     (wr_en),
        .o_wr_bank   (wr_bank),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_bank   (rd_bank),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

endmodule

[rtl/pwgrle_store.sv]
// Two line stores with one write and one registered read port.
// Depends on pwgrle_pkg for the pixel width and the default depth.
module pwgrle_store #(
    parameter int MAX_WIDTH = pwgrle_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic                         i_wr_bank,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [pwgrle_pkg::PIX_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic                         i_rd_bank,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [pwgrle_pkg::PIX_W-1:0] o_rd_data
);

    logic [pwgrle_pkg::PIX_W-1:0] r_mem_a [MAX_WIDTH];
    logic [pwgrle_pkg::PIX_W-1:0] r_mem_b [MAX_WIDTH];
    logic [pwgrle_pkg::PIX_W-1:0] r_rd_a;
    logic [pwgrle_pkg::PIX_W-1:0] r_rd_b;
    logic                         r_rd_bank;

    // Bank A
    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_bank) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en && !i_rd_bank) begin
            r_rd_a <= r_mem_a[i_rd_addr];
        end
    end

    // Bank B
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_bank) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en && i_rd_bank) begin
            r_rd_b <= r_mem_b[i_rd_addr];
        end
    end

    // Remember which bank was read so the right data is returned.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_bank <= i_rd_bank;
        end
    end

    assign o_rd_data = r_rd_bank ? r_rd_b : r_rd_a;

endmodule

[rtl/pwgrle_ctrl.sv]
// Sequencer of the encoder: line filling, line comparison, run scanning and
// token emission, plus the result register. Depends on pwgrle_pkg.
module pwgrle_ctrl #(
    parameter int MAX_WIDTH = pwgrle_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH),
    parameter int CW        = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pwgrle_pkg::t_cfg                i_cfg,
    input  logic [CW-1:0]                   i_width,
    // Input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_in_mode,
    input  logic [pwgrle_pkg::PIX_W-1:0]    i_in_pixel,
    // Result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pwgrle_pkg::PIX_W-1:0]    o_out_data,
    output logic [pwgrle_pkg::USER_W-1:0]   o_out_user,
    output logic                            o_out_last,
    // Line store port
    output logic                            o_wr_en,
    output logic                            o_wr_bank,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [pwgrle_pkg::PIX_W-1:0]    o_wr_data,
    output logic                            o_rd_en,
    output logic                            o_rd_bank,
    output logic [AW-1:0]                   o_rd_addr,
    input  logic [pwgrle_pkg::PIX_W-1:0]    i_rd_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PUSH  = 6'b000010,
        S_FIRST = 6'b000100,
        S_CMP   = 6'b001000,
        S_PIX   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_held_sel, n_held_sel;
    logic                          r_held_vld, n_held_vld;
    logic [7:0]                    r_rep_cnt, n_rep_cnt;
    logic [CW-1:0]                 r_fill_col, n_fill_col;
    logic [pwgrle_pkg::PAGE_H_W-1:0] r_row, n_row;
    logic                          r_match, n_match;
    pwgrle_pkg::t_pend             r_pend, n_pend;
    pwgrle_pkg::t_phase            r_phase, n_phase;
    logic [CW-1:0]                 r_emit_col, n_emit_col;
    logic [7:0]                    r_run, n_run;
    // Scan and push working registers
    logic [7:0]                    r_cnt, n_cnt;
    logic                          r_rep, n_rep;
    logic [pwgrle_pkg::PIX_W-1:0]  r_first, n_first;
    logic [pwgrle_pkg::PIX_W-1:0]  r_prev, n_prev;
    logic [pwgrle_pkg::PIX_W-1:0]  r_pv, n_pv;
    // Pending result
    logic [pwgrle_pkg::PIX_W-1:0]  r_res_data, n_res_data;
    logic [pwgrle_pkg::USER_W-1:0] r_res_user, n_res_user;
    logic                          r_res_last, n_res_last;
    // Output register
    logic                          r_o_valid, n_o_valid;
    logic [pwgrle_pkg::PIX_W-1:0]  r_o_data, n_o_data;
    logic [pwgrle_pkg::USER_W-1:0] r_o_user, n_o_user;
    logic                          r_o_last, n_o_last;

    logic [pwgrle_pkg::PIX_W-1:0]  rd_m;
    logic [CW:0]                   scan_next;
    logic [CW:0]                   scan_now;
    logic [CW-1:0]                 col_step;
    logic [pwgrle_pkg::PAGE_H_W:0] row_inc;
    logic                          page_end;
    logic                          mismatch;
    logic                          line_eq;
    logic                          stop;
    logic                          cont;
    logic [7:0]                    stop_cnt;
    logic [7:0]                    cnt_inc;
    logic                          tok_done;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_user  = r_o_user;
    assign o_out_last  = r_o_last;

    assign rd_m      = i_rd_data & i_cfg.mask;
    assign row_inc   = {1'b0, r_row} + 1'b1;
    assign page_end  = row_inc >= {1'b0, i_cfg.height};
    assign cnt_inc   = r_cnt + 8'd1;
    assign scan_now  = {1'b0, r_emit_col} + {{(CW-7){1'b0}}, r_cnt};
    assign scan_next = {1'b0, r_emit_col} + {{(CW-7){1'b0}}, cnt_inc};

    // Next-state logic of the whole sequencer
    always_comb begin
        n_state    = r_state;
        n_held_sel = r_held_sel;
        n_held_vld = r_held_vld;
        n_rep_cnt  = r_rep_cnt;
        n_fill_col = r_fill_col;
        n_row      = r_row;
        n_match    = r_match;
        n_pend     = r_pend;
        n_phase    = r_phase;
        n_emit_col = r_emit_col;
        n_run      = r_run;
        n_cnt      = r_cnt;
        n_rep      = r_rep;
        n_first    = r_first;
        n_prev     = r_prev;
        n_pv       = r_pv;
        n_res_data = r_res_data;
        n_res_user = r_res_user;
        n_res_last = r_res_last;
        n_o_valid  = r_o_valid;
        n_o_data   = r_o_data;
        n_o_user   = r_o_user;
        n_o_last   = r_o_last;
        o_wr_en    = 1'b0;
        o_wr_bank  = ~r_held_sel;
        o_wr_addr  = r_fill_col[AW-1:0];
        o_wr_data  = i_in_pixel & i_cfg.mask;
        o_rd_en    = 1'b0;
        o_rd_bank  = r_held_sel;
        o_rd_addr  = r_emit_col[AW-1:0];
        mismatch   = 1'b0;
        line_eq    = 1'b0;
        stop       = 1'b0;
        cont       = 1'b0;
        stop_cnt   = r_cnt;
        col_step   = r_emit_col;
        tok_done   = 1'b0;

        // The result register empties when the far side takes its item.
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_data = '0;
                    n_res_user = '0;
                    n_res_last = 1'b0;
                    n_state    = S_OUT;
                    if (i_in_mode == pwgrle_pkg::MODE_PUSH) begin
                        // Store the pixel and fetch the held pixel of the same column.
                        if (r_pend == pwgrle_pkg::PEND_NONE) begin
                            o_wr_en   = 1'b1;
                            o_rd_en   = 1'b1;
                            o_rd_addr = r_fill_col[AW-1:0];
                            n_pv      = i_in_pixel & i_cfg.mask;
                            n_state   = S_PUSH;
                        end
                    end else if (r_pend != pwgrle_pkg::PEND_NONE) begin
                        unique case (r_phase)
                            pwgrle_pkg::PH_REPEAT: begin
                                n_res_user = pwgrle_pkg::pack_user(1'b0, 1'b1,
                                                 pwgrle_pkg::KIND_REPEAT, 1'b0);
                                n_res_data = {24'd0, r_rep_cnt};
                                n_phase    = pwgrle_pkg::PH_CTRL;
                            end
                            pwgrle_pkg::PH_CTRL: begin
                                o_rd_en = 1'b1;
                                n_cnt   = 8'd1;
                                n_state = S_FIRST;
                            end
                            default: begin
                                o_rd_en = 1'b1;
                                n_state = S_PIX;
                            end
                        endcase
                    end
                end
            end

            S_PUSH: begin
                mismatch = r_held_vld && (rd_m != r_pv);
                line_eq  = r_match && !mismatch;
                n_match  = line_eq;
                n_res_user = pwgrle_pkg::pack_user(1'b1, 1'b0, pwgrle_pkg::KIND_REPEAT, 1'b0);
                if ({1'b0, r_fill_col} + 1'b1 >= {1'b0, i_width}) begin
                    // Line complete: start, extend or close the repeat group.
                    if (!r_held_vld) begin
                        n_held_sel = ~r_held_sel;
                        n_held_vld = 1'b1;
                        n_rep_cnt  = 8'd0;
                        if (page_end) begin
                            n_pend = pwgrle_pkg::PEND_PAGE;
                        end
                    end else if (line_eq && r_rep_cnt < pwgrle_pkg::REP_LIMIT) begin
                        n_rep_cnt = r_rep_cnt + 8'd1;
                        if (page_end) begin
                            n_pend = pwgrle_pkg::PEND_PAGE;
                        end
                    end else begin
                        n_pend = page_end ? pwgrle_pkg::PEND_SWAP_PAGE
                                          : pwgrle_pkg::PEND_SWAP;
                    end
                    n_phase    = pwgrle_pkg::PH_REPEAT;
                    n_emit_col = '0;
                    n_run      = 8'd0;
                    n_fill_col = '0;
                    n_match    = 1'b1;
                    n_row      = page_end ? '0 : row_inc[pwgrle_pkg::PAGE_H_W-1:0];
                end else begin
                    n_fill_col = r_fill_col + 1'b1;
                end
                n_state = S_OUT;
            end

            S_FIRST: begin
                // First pixel of the run; look at the next one if the line allows.
                n_first = rd_m;
                n_prev  = rd_m;
                n_rep   = 1'b1;
                if (scan_now < {1'b0, i_width}) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = scan_now[AW-1:0];
                    n_state   = S_CMP;
                end else begin
                    stop     = 1'b1;
                    stop_cnt = r_cnt;
                end
            end

            S_CMP: begin
                // Decide the run type on the second pixel, then extend the run.
                if (r_cnt == 8'd1) begin
                    n_rep = (rd_m == r_first);
                    cont  = 1'b1;
                end else if (r_rep) begin
                    cont = (rd_m == r_first);
                end else begin
                    cont = (rd_m != r_prev);
                end
                n_prev = rd_m;
                if (cont) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc < pwgrle_pkg::RUN_MAX && scan_next < {1'b0, i_width}) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = scan_next[AW-1:0];
                    end else begin
                        stop     = 1'b1;
                        stop_cnt = cnt_inc;
                    end
                end else begin
                    stop     = 1'b1;
                    stop_cnt = r_cnt;
                end
            end

            S_PIX: begin
                n_res_user = pwgrle_pkg::pack_user(1'b0, 1'b1, pwgrle_pkg::KIND_PIXEL, 1'b0);
                n_res_data = rd_m;
                if (r_phase == pwgrle_pkg::PH_LIT) begin
                    col_step = r_emit_col + 1'b1;
                    n_run    = (r_run > 8'd0) ? r_run - 8'd1 : 8'd0;
                    tok_done = (n_run == 8'd0);
                end else begin
                    col_step = r_emit_col + {{(CW-8){1'b0}}, r_run};
                    n_run    = 8'd0;
                    tok_done = 1'b1;
                end
                n_emit_col = col_step;
                if (tok_done) begin
                    if (col_step >= i_width) begin
                        // End of the encoded line: release or swap the held line.
                        n_res_last = 1'b1;
                        if (r_pend == pwgrle_pkg::PEND_PAGE) begin
                            n_res_user = pwgrle_pkg::pack_user(1'b0, 1'b1,
                                             pwgrle_pkg::KIND_PIXEL, 1'b1);
                            n_held_vld = 1'b0;
                            n_pend     = pwgrle_pkg::PEND_NONE;
                        end else begin
                            n_held_sel = ~r_held_sel;
                            n_held_vld = 1'b1;
                            n_pend     = (r_pend == pwgrle_pkg::PEND_SWAP_PAGE)
                                         ? pwgrle_pkg::PEND_PAGE : pwgrle_pkg::PEND_NONE;
                        end
                        n_rep_cnt  = 8'd0;
                        n_phase    = pwgrle_pkg::PH_REPEAT;
                        n_emit_col = '0;
                    end else begin
                        n_phase = pwgrle_pkg::PH_CTRL;
                    end
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = r_res_data;
                    n_o_user  = r_res_user;
                    n_o_last  = r_res_last;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Run length settled: emit its control byte.
        if (stop) begin
            n_res_user = pwgrle_pkg::pack_user(1'b0, 1'b1, pwgrle_pkg::KIND_CTRL, 1'b0);
            n_res_last = 1'b0;
            n_run      = stop_cnt;
            if (n_rep) begin
                n_res_data = {24'd0, stop_cnt - 8'd1};
                n_phase    = pwgrle_pkg::PH_RPIX;
            end else begin
                n_res_data = {24'd0, 8'(pwgrle_pkg::LIT_BASE - {1'b0, stop_cnt})};
                n_phase    = pwgrle_pkg::PH_LIT;
            end
            n_state = S_OUT;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_held_sel <= 1'b0;
            r_held_vld <= 1'b0;
            r_rep_cnt  <= 8'd0;
            r_fill_col <= '0;
            r_row      <= '0;
            r_match    <= 1'b1;
            r_pend     <= pwgrle_pkg::PEND_NONE;
            r_phase    <= pwgrle_pkg::PH_REPEAT;
            r_emit_col <= '0;
            r_run      <= 8'd0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_held_sel <= n_held_sel;
            r_held_vld <= n_held_vld;
            r_rep_cnt  <= n_rep_cnt;
            r_fill_col <= n_fill_col;
            r_row      <= n_row;
            r_match    <= n_match;
            r_pend     <= n_pend;
            r_phase    <= n_phase;
            r_emit_col <= n_emit_col;
            r_run      <= n_run;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_rep      <= n_rep;
        r_first    <= n_first;
        r_prev     <= n_prev;
        r_pv       <= n_pv;
        r_res_data <= n_res_data;
        r_res_user <= n_res_user;
        r_res_last <= n_res_last;
        r_o_data   <= n_o_data;
        r_o_user   <= n_o_user;
        r_o_last   <= n_o_last;
    end

endmodule

[rtl/pwgrle_checker.sv]
// Port-level checks of the raster line encoder, bound to the top level.
// Depends on pwgrle_pkg and pwg_raster_line_encoder.
module pwgrle_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [pwgrle_pkg::PIX_W-1:0]      o_m_axis_tdata,
    input logic [pwgrle_pkg::USER_W-1:0]     o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);

    // A stalled result item holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item changed while stalled");

    // A push acknowledgement never carries a token.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("accepted and token_valid both set");

    // Line end only on a pixel token.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            o_m_axis_tuser[1] && o_m_axis_tuser[3:2] == pwgrle_pkg::KIND_PIXEL)
        else $error("line end on a non-pixel item");

    // Page end is always also a line end.
    a_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[4] |-> o_m_axis_tlast)
        else $error("page end without line end");

endmodule

bind pwg_raster_line_encoder pwgrle_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
